[src/ipsba_pkg.sv]
// shared types and constants for the patch section parser
`default_nettype none

package ipsba_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam logic [23:0] EOF_MARK        = 24'h454F46;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_OK    = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    typedef struct packed {
        logic [7:0] patch_byte;
        logic       section_end;
    } patch_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] write_offset;
        logic [12:0] run_length;
        logic [7:0]  write_value;
        logic        last_of_run;
    } result_item_t;

    // work handed from the parser to the emitter: an optional result
    // plus an optional trailing section error
    typedef struct packed {
        logic        has_main;
        logic [1:0]  kind;
        logic [11:0] write_offset;
        logic [12:0] run_length;
        logic [7:0]  write_value;
        logic        tail_error;
    } work_t;

endpackage

`default_nettype wire

[src/ips_block_patch_applier_top.sv]
// top level of the patch section parser
//
// input channel: patch bytes of one section, starting after the 5-byte
// header, with section_end set on the final byte; an item is taken when
// push is high and full is low.
// result channel: byte writes, fill runs and one section ok or section
// error per section; the oldest result is on result while empty is low and
// leaves when pop is high.
// one patch byte is taken per cycle while full is low; a byte yields zero,
// one or two results, which reach result through the work queue and the
// output register; results leave at most one per cycle through the output
// register, so a byte giving two results hands them out one after the other.
// a four-entry work queue sits between parser and emitter; when the
// receiver stalls the queue fills and full rises, holding off the source.
// reset empties the queue and the output register and leaves the parser
// expecting the first offset byte; the parser returns there after every
// section end.
`default_nettype none

module ips_block_patch_applier_top
    import ipsba_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire patch_item_t patch,
    output logic             empty,
    input  wire logic        pop,
    output result_item_t     result
);

    logic  accept;
    logic  work_push;
    work_t work;
    work_t q_head;
    logic  q_pop;
    logic  q_empty;

    assign accept = push && !full;

    ipsba_parse #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .patch     (patch),
        .work_push (work_push),
        .work      (work)
    );

    ipsba_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (work_push),
        .wr_data (work),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (full),
        .empty   (q_empty)
    );

    ipsba_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire

[src/ipsba_parse.sv]
// front end: record parser that turns each patch byte into work for the queue
`default_nettype none

module ipsba_parse
    import ipsba_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire patch_item_t patch,
    output logic             work_push,
    output work_t            work
);

    typedef enum logic [3:0] {
        PH_OFF0, PH_OFF1, PH_OFF2, PH_LEN0, PH_LEN1,
        PH_FILL0, PH_FILL1, PH_VALUE, PH_DATA, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] offset_reg, offset_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] fill_reg, fill_next;
    logic [15:0] left_reg, left_next;
    logic [11:0] wptr_reg, wptr_next;

    logic [7:0]  b;
    logic [15:0] len_full;
    logic [15:0] addend;
    logic [24:0] sum;
    logic        overrun;
    logic [23:0] offset_new;

    assign b          = patch.patch_byte;
    assign len_full   = {len_hi_reg, b};
    assign offset_new = {offset_reg[15:0], b};

    // one adder serves both the normal and the fill overrun check
    assign addend  = (phase_reg == PH_LEN1) ? len_full : fill_reg;
    assign sum     = {1'b0, offset_reg} + {9'd0, addend};
    assign overrun = sum > 25'(BLOCK_BYTES);

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        len_hi_next = len_hi_reg;
        fill_next   = fill_reg;
        left_next   = left_reg;
        wptr_next   = wptr_reg;
        work        = '0;

        unique case (phase_reg)
            PH_OFF0:
            begin
                offset_next = {16'd0, b};
                phase_next  = PH_OFF1;
            end
            PH_OFF1:
            begin
                offset_next = offset_new;
                phase_next  = PH_OFF2;
            end
            PH_OFF2:
            begin
                offset_next = offset_new;
                if (offset_new == EOF_MARK)
                begin
                    phase_next    = PH_DONE;
                    work.has_main = 1'b1;
                    work.kind     = KIND_OK;
                end
                else
                begin
                    phase_next = PH_LEN0;
                end
            end
            PH_LEN0:
            begin
                len_hi_next = b;
                phase_next  = PH_LEN1;
            end
            PH_LEN1:
            begin
                if (len_full == 16'd0)
                begin
                    phase_next = PH_FILL0;
                end
                else if (overrun)
                begin
                    phase_next    = PH_DONE;
                    work.has_main = 1'b1;
                    work.kind     = KIND_ERROR;
                end
                else
                begin
                    left_next  = len_full;
                    wptr_next  = offset_reg[11:0];
                    phase_next = PH_DATA;
                end
            end
            PH_FILL0:
            begin
                fill_next  = {8'd0, b};
                phase_next = PH_FILL1;
            end
            PH_FILL1:
            begin
                fill_next  = {fill_reg[7:0], b};
                phase_next = PH_VALUE;
            end
            PH_VALUE:
            begin
                if (overrun)
                begin
                    phase_next    = PH_DONE;
                    work.has_main = 1'b1;
                    work.kind     = KIND_ERROR;
                end
                else
                begin
                    phase_next = PH_OFF0;
                    if (fill_reg != 16'd0)
                    begin
                        work.has_main     = 1'b1;
                        work.kind         = KIND_FILL;
                        work.write_offset = offset_reg[11:0];
                        work.run_length   = fill_reg[12:0];
                        work.write_value  = b;
                    end
                end
            end
            PH_DATA:
            begin
                work.has_main     = 1'b1;
                work.kind         = KIND_WRITE;
                work.write_offset = wptr_reg;
                work.run_length   = 13'd1;
                work.write_value  = b;
                wptr_next         = wptr_reg + 12'd1;
                left_next         = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = PH_OFF0;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // section end: error unless the marker or an error already ended parsing
        if (patch.section_end)
        begin
            work.tail_error = (phase_next != PH_DONE);
            phase_next      = PH_OFF0;
        end
    end

    assign work_push = accept && (work.has_main || work.tail_error);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OFF0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            offset_reg <= offset_next;
            len_hi_reg <= len_hi_next;
            fill_reg   <= fill_next;
            left_reg   <= left_next;
            wptr_reg   <= wptr_next;
        end
    end

endmodule

`default_nettype wire

[src/ipsba_queue.sv]
// short work queue between the parser and the result emitter
`default_nettype none

module ipsba_queue
    import ipsba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire work_t wr_data,
    input  wire logic  rd_en,
    output work_t      rd_data,
    output logic       full,
    output logic       empty
);

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    work_t           slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wptr_reg;
    logic [PtrW-1:0] rptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_wr;
    logic            do_rd;

    assign full    = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[src/ipsba_emit.sv]
// back end: expands queued work into result items behind an output register
`default_nettype none

module ipsba_emit
    import ipsba_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  wire work_t  q_head,
    output logic        q_pop,
    output result_item_t result,
    output logic        empty,
    input  wire logic   pop
);

    result_item_t out_reg, out_next;
    logic         valid_reg, valid_next;
    logic         sel_reg, sel_next;
    logic         load;

    assign load = !valid_reg || pop;

    always_comb
    begin
        out_next   = out_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        q_pop      = 1'b0;

        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                if (!sel_reg && q_head.has_main)
                begin
                    out_next.kind         = q_head.kind;
                    out_next.write_offset = q_head.write_offset;
                    out_next.run_length   = q_head.run_length;
                    out_next.write_value  = q_head.write_value;
                    out_next.last_of_run  = !q_head.tail_error;
                    // hold the entry when its trailing error is still due
                    sel_next = q_head.tail_error;
                    q_pop    = !q_head.tail_error;
                end
                else
                begin
                    out_next             = '0;
                    out_next.kind        = KIND_ERROR;
                    out_next.last_of_run = 1'b1;
                    sel_next             = 1'b0;
                    q_pop                = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result = out_reg;
    assign empty  = !valid_reg;

endmodule

`default_nettype wire
